[design/range_add_range_max_tree_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the range-add / range-max tree
// Shared property templates, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RANGE_ADD_RANGE_MAX_TREE_TOP_DEFINES_SVH
`define RANGE_ADD_RANGE_MAX_TREE_TOP_DEFINES_SVH

// antecedent in this cycle implies consequent in the next one
`define RAMT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// antecedent implies consequent in the same cycle
`define RAMT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

[design/ramt_pkg.sv]
// ----------------------------------------------------------------------------
// ramt_pkg
// Types and constants shared by the range-add / range-max tree modules.
// ----------------------------------------------------------------------------
package ramt_pkg;

   localparam int IN_POS_W = 11;
   localparam int OUT_W    = 32;
   localparam int IN_VAL_W = 32;

   localparam logic               OP_ADD   = 1'b0;
   localparam logic               OP_QUERY = 1'b1;
   localparam logic [IN_POS_W-1:0] POS_RESET = 11'd1024;
   localparam logic [OUT_W-1:0]    EMPTY_MARK = -32'sd99999999;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_VISIT_RD,
      ST_VISIT_PD,
      ST_PUSH_RD,
      ST_PUSH_WR,
      ST_DECIDE,
      ST_RETURN,
      ST_COMB_RD,
      ST_COMB_MAX,
      ST_COMB_WR,
      ST_RESULT
   } ctrl_state_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_CLR,
      DP_LOAD,
      DP_VISIT_RD,
      DP_VISIT_PD,
      DP_CH_RD,
      DP_CH_WR,
      DP_COVER,
      DP_DOWN,
      DP_SIB,
      DP_UP,
      DP_COMB_RD,
      DP_COMB_MAX,
      DP_COMB_WR,
      DP_RESULT
   } dp_op_type;

   typedef struct packed {
      logic pend_nz;
      logic leaf;
      logic no_ovl;
      logic covered;
      logic at_root;
      logic is_left;
      logic is_query;
      logic empty;
      logic clr_last;
      logic rsp_busy;
   } dp_stat_type;

endpackage

[design/ramt_dp.sv]
// ----------------------------------------------------------------------------
// ramt_dp
// Tree datapath: node max and pending add memories (two nodes per row),
// walk registers, ancestor stack, accumulator and result register.
// ----------------------------------------------------------------------------
module ramt_dp import ramt_pkg::*; #(
   parameter int LEAVES     = 1024,
   parameter int VALUE_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_op_type            op,
   output dp_stat_type          stat,
   input  logic                 req_op,
   input  logic [IN_POS_W-1:0]  req_range_lo,
   input  logic [IN_POS_W-1:0]  req_range_hi,
   input  logic [IN_VAL_W-1:0]  req_add_value,
   input  logic                 csr_wen,
   input  logic [IN_POS_W-1:0]  csr_wdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [OUT_W-1:0]     rsp_range_max
);

   localparam int VB     = VALUE_BITS;
   localparam int NODE_W = $clog2(4 * LEAVES);
   localparam int ROW_W  = NODE_W - 1;
   localparam int ROWS   = 2 * LEAVES;
   localparam int POS_W  = $clog2(LEAVES + 1);
   localparam int CMP_W  = ((POS_W > IN_POS_W) ? POS_W : IN_POS_W) + 1;
   localparam int DEPTH  = $clog2(LEAVES) + 2;
   localparam int STK_W  = $clog2(DEPTH);
   localparam int LVL_W  = $clog2(DEPTH + 1);

   // row j holds nodes 2j (low half) and 2j+1 (high half)
   logic [2*VB-1:0] nm_mem [ROWS];
   logic [2*VB-1:0] pd_mem [ROWS];
   logic [2*VB-1:0] nm_rd_ff, pd_rd_ff;
   logic [ROW_W-1:0] nm_raddr, pd_raddr, nm_waddr, pd_waddr;
   logic [2*VB-1:0] nm_wdata, pd_wdata;
   logic nm_we, pd_we;

   logic [IN_POS_W-1:0] pos_ff;
   logic [ROW_W-1:0] clr_ff;
   logic [NODE_W-1:0] node_ff;
   logic [POS_W-1:0] l_ff, r_ff;
   logic [LVL_W-1:0] lvl_ff;
   logic [2*POS_W-1:0] stk [DEPTH];
   logic q_ff;
   logic [IN_POS_W-1:0] a_ff, b_ff;
   logic [VB-1:0] v_ff, cur_ff, pend_ff, acc_ff;
   logic acc_ok_ff;
   logic [2*VB-1:0] nmrow_ff;
   logic rsp_valid_ff;
   logic [OUT_W-1:0] rsp_data_ff;

   logic [VB-1:0] addv, hn, hp, psum, cover_v, cmax, nm_lo, nm_hi;
   logic [2*VB-1:0] nmrow_in;
   logic [POS_W-1:0] n_used, mid, top_l, top_r;
   logic [POS_W:0] lr_sum;
   logic [LVL_W-1:0] lvl_m1;
   logic [CMP_W-1:0] lx, rx, ax, bx;
   logic [ROW_W-1:0] own_row, child_row;
   logic [OUT_W-1:0] acc_out;
   logic half;

   generate
      if (VB <= IN_VAL_W) begin : g_in_narrow
         assign addv = req_add_value[VB-1:0];
      end else begin : g_in_wide
         assign addv = {{(VB-IN_VAL_W){req_add_value[IN_VAL_W-1]}}, req_add_value};
      end
      if (VB >= OUT_W) begin : g_out_narrow
         assign acc_out = acc_ff[OUT_W-1:0];
      end else begin : g_out_wide
         assign acc_out = {{(OUT_W-VB){acc_ff[VB-1]}}, acc_ff};
      end
   endgenerate

   assign n_used = (CMP_W'(pos_ff) > CMP_W'(LEAVES)) ? POS_W'(LEAVES) : POS_W'(pos_ff);
   assign half      = node_ff[0];
   assign own_row   = node_ff[NODE_W-1:1];
   assign child_row = node_ff[ROW_W-1:0];
   assign lr_sum = {1'b0, l_ff} + {1'b0, r_ff};
   assign mid    = lr_sum[POS_W:1];
   assign lvl_m1 = lvl_ff - LVL_W'(1);
   assign {top_l, top_r} = stk[lvl_m1[STK_W-1:0]];

   assign lx = CMP_W'(l_ff);
   assign rx = CMP_W'(r_ff);
   assign ax = CMP_W'(a_ff);
   assign bx = CMP_W'(b_ff);

   assign hn   = half ? nm_rd_ff[2*VB-1:VB] : nm_rd_ff[VB-1:0];
   assign hp   = half ? pd_rd_ff[2*VB-1:VB] : pd_rd_ff[VB-1:0];
   assign psum = hn + hp;
   assign nmrow_in = half ? {psum, nm_rd_ff[VB-1:0]} : {nm_rd_ff[2*VB-1:VB], psum};
   assign cover_v  = cur_ff + v_ff;
   assign nm_lo = nm_rd_ff[VB-1:0];
   assign nm_hi = nm_rd_ff[2*VB-1:VB];
   assign cmax  = ($signed(nm_hi) > $signed(nm_lo)) ? nm_hi : nm_lo;

   always_comb begin
      stat.pend_nz  = (hp != '0);
      stat.leaf     = (l_ff == r_ff);
      stat.no_ovl   = (lx > bx) || (ax > rx);
      stat.covered  = (ax <= lx) && (bx >= rx);
      stat.at_root  = (lvl_ff == '0);
      stat.is_left  = !node_ff[0];
      stat.is_query = (q_ff == OP_QUERY);
      stat.empty    = (n_used == '0);
      stat.clr_last = (clr_ff == ROW_W'(ROWS - 1));
      stat.rsp_busy = rsp_valid_ff && !rsp_tready;
   end

   // memory port selection
   always_comb begin
      nm_raddr = own_row;
      pd_raddr = own_row;
      nm_we = 1'b0;
      pd_we = 1'b0;
      nm_waddr = own_row;
      pd_waddr = own_row;
      nm_wdata = nmrow_in;
      pd_wdata = half ? {{VB{1'b0}}, pd_rd_ff[VB-1:0]} : {pd_rd_ff[2*VB-1:VB], {VB{1'b0}}};
      case (op)
         DP_CLR: begin
            nm_we = 1'b1;
            pd_we = 1'b1;
            nm_waddr = clr_ff;
            pd_waddr = clr_ff;
            nm_wdata = '0;
            pd_wdata = '0;
         end
         DP_VISIT_PD: begin
            nm_we = stat.pend_nz;
            pd_we = stat.pend_nz;
         end
         DP_CH_RD: pd_raddr = child_row;
         DP_CH_WR: begin
            pd_we = 1'b1;
            pd_waddr = child_row;
            pd_wdata = {pd_rd_ff[2*VB-1:VB] + pend_ff, pd_rd_ff[VB-1:0] + pend_ff};
         end
         DP_COVER: begin
            nm_we = !stat.is_query;
            nm_wdata = half ? {cover_v, nmrow_ff[VB-1:0]} : {nmrow_ff[2*VB-1:VB], cover_v};
         end
         DP_COMB_RD: nm_raddr = child_row;
         DP_COMB_WR: begin
            nm_we = 1'b1;
            nm_wdata = half ? {cur_ff, nm_lo} : {nm_hi, cur_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (nm_we) begin
         nm_mem[nm_waddr] <= nm_wdata;
      end
      if (pd_we) begin
         pd_mem[pd_waddr] <= pd_wdata;
      end
      nm_rd_ff <= nm_mem[nm_raddr];
      pd_rd_ff <= pd_mem[pd_raddr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_RESET;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            pos_ff <= csr_wdata;
            clr_ff <= '0;
         end else if (op == DP_CLR) begin
            clr_ff <= stat.clr_last ? '0 : clr_ff + ROW_W'(1);
         end
         if (op == DP_RESULT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // walk and payload registers
   always_ff @(posedge clock) begin
      case (op)
         DP_LOAD: begin
            q_ff <= req_op;
            a_ff <= req_range_lo;
            b_ff <= req_range_hi;
            v_ff <= addv;
            node_ff <= NODE_W'(1);
            l_ff <= POS_W'(1);
            r_ff <= n_used;
            lvl_ff <= '0;
            acc_ok_ff <= 1'b0;
         end
         DP_VISIT_PD: begin
            cur_ff <= psum;
            pend_ff <= hp;
            nmrow_ff <= nmrow_in;
         end
         DP_COVER: begin
            pend_ff <= v_ff;
            if (stat.is_query) begin
               acc_ok_ff <= 1'b1;
               if (!acc_ok_ff || ($signed(cur_ff) > $signed(acc_ff))) begin
                  acc_ff <= cur_ff;
               end
            end
         end
         DP_DOWN: begin
            stk[lvl_ff[STK_W-1:0]] <= {l_ff, r_ff};
            lvl_ff <= lvl_ff + LVL_W'(1);
            node_ff <= {node_ff[NODE_W-2:0], 1'b0};
            r_ff <= mid;
         end
         DP_SIB: begin
            node_ff <= node_ff + NODE_W'(1);
            l_ff <= r_ff + POS_W'(1);
            r_ff <= top_r;
         end
         DP_UP: begin
            node_ff <= {1'b0, node_ff[NODE_W-1:1]};
            l_ff <= top_l;
            r_ff <= top_r;
            lvl_ff <= lvl_m1;
         end
         DP_COMB_MAX: cur_ff <= cmax;
         DP_RESULT: rsp_data_ff <= acc_ok_ff ? acc_out : EMPTY_MARK;
         default: ;
      endcase
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_range_max = rsp_data_ff;

endmodule

[design/ramt_ctrl.sv]
// ----------------------------------------------------------------------------
// ramt_ctrl
// Sequencer for the tree walk: clearing pass, node visits, pending-add
// push, descent and return, parent max rebuild and result hand-off.
// ----------------------------------------------------------------------------
module ramt_ctrl import ramt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        csr_wen,
   input  dp_stat_type stat,
   output dp_op_type   op
);

   ctrl_state_type state_ff, state_in;
   logic after_cover_ff, after_cover_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         after_cover_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         after_cover_ff <= after_cover_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      after_cover_in = after_cover_ff;
      op = DP_NOP;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            op = DP_CLR;
            if (stat.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = !csr_wen;
            if (req_tvalid && !csr_wen) begin
               op = DP_LOAD;
               state_in = stat.empty ? ST_RESULT : ST_VISIT_RD;
            end
         end
         ST_VISIT_RD: begin
            op = DP_VISIT_RD;
            state_in = ST_VISIT_PD;
         end
         ST_VISIT_PD: begin
            op = DP_VISIT_PD;
            after_cover_in = 1'b0;
            state_in = (stat.pend_nz && !stat.leaf) ? ST_PUSH_RD : ST_DECIDE;
         end
         ST_PUSH_RD: begin
            op = DP_CH_RD;
            state_in = ST_PUSH_WR;
         end
         ST_PUSH_WR: begin
            op = DP_CH_WR;
            state_in = after_cover_ff ? ST_RETURN : ST_DECIDE;
         end
         ST_DECIDE: begin
            if (stat.no_ovl) begin
               state_in = ST_RETURN;
            end else if (stat.covered) begin
               op = DP_COVER;
               if (stat.is_query || stat.leaf) begin
                  state_in = ST_RETURN;
               end else begin
                  after_cover_in = 1'b1;
                  state_in = ST_PUSH_RD;
               end
            end else begin
               op = DP_DOWN;
               state_in = ST_VISIT_RD;
            end
         end
         ST_RETURN: begin
            if (stat.at_root) begin
               state_in = ST_RESULT;
            end else if (stat.is_left) begin
               op = DP_SIB;
               state_in = ST_VISIT_RD;
            end else begin
               op = DP_UP;
               state_in = stat.is_query ? ST_RETURN : ST_COMB_RD;
            end
         end
         ST_COMB_RD: begin
            op = DP_COMB_RD;
            state_in = ST_COMB_MAX;
         end
         ST_COMB_MAX: begin
            op = DP_COMB_MAX;
            state_in = ST_COMB_WR;
         end
         ST_COMB_WR: begin
            op = DP_COMB_WR;
            state_in = ST_RETURN;
         end
         ST_RESULT: begin
            if (!stat.is_query) begin
               state_in = ST_IDLE;
            end else if (!stat.rsp_busy) begin
               op = DP_RESULT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
      if (csr_wen) begin
         state_in = ST_CLEAR;
      end
   end

endmodule

[design/range_add_range_max_tree_top.sv]
// ----------------------------------------------------------------------------
// range_add_range_max_tree_top
// Range add / range max over positions 1..n held in a lazy segment tree.
//
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | tuser: op; tdata: lo, hi, add value
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata: range max (queries only)
//  csr     | in  | csr_wen                | csr_wdata: positions in use
//
// One transaction at a time. Each visited node needs a read (one read port
// per node memory), a push of pending adds and, for adds, a max rebuild on
// the way up; at most four nodes per level are visited.
// After reset and after every csr write, a clearing pass over all 2*LEAVES
// memory rows runs with req_tready low. A query result waits in the output
// register; the next transaction is taken meanwhile and stalls only at its
// own result.
// ----------------------------------------------------------------------------
`include "range_add_range_max_tree_top_defines.svh"

module range_add_range_max_tree_top import ramt_pkg::*; #(
   parameter int LEAVES     = 1024,
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // range_lo[10:0], range_hi[21:11], add_value[53:22]
   input  logic        req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // range_max[31:0]
   input  logic        csr_wen,
   input  logic [10:0] csr_wdata
);

   dp_op_type   op;
   dp_stat_type stat;

   ramt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .csr_wen    (csr_wen),
      .stat       (stat),
      .op         (op)
   );

   ramt_dp #(
      .LEAVES     (LEAVES),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .op            (op),
      .stat          (stat),
      .req_op        (req_tuser),
      .req_range_lo  (req_tdata[10:0]),
      .req_range_hi  (req_tdata[21:11]),
      .req_add_value (req_tdata[53:22]),
      .csr_wen       (csr_wen),
      .csr_wdata     (csr_wdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_range_max (rsp_tdata)
   );

   `RAMT_ASSERT_NEXT(a_accept_busy, req_tvalid && req_tready, !req_tready, "taken twice")
   `RAMT_ASSERT_NEXT(a_csr_clears, csr_wen, !req_tready, "no clear after csr write")
   `RAMT_ASSERT_NOW(a_rsp_rise, $rose(rsp_tvalid), $past(!req_tready), "stray result")

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Range-add / range-max tree testbench
// Streams add and query transactions into the block under random idling on
// both sides. A scoreboard keeps its own lazy segment tree and checks every
// query result in order. The positions register is swept through several
// settings, its extremes among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class max_tree_scoreboard;
   localparam int NODES = 4096;
   bit signed [31:0] node_max[NODES];
   bit signed [31:0] pend[NODES];
   int               n_pos;
   bit signed [31:0] pending_max[$];
   int               mismatches;

   function void clear_tree(int positions);
      foreach (node_max[k]) begin
         node_max[k] = 0;
         pend[k]     = 0;
      end
      n_pos = (positions > 1024) ? 1024 : positions;
   endfunction

   function void push(int i, int l, int r);
      if (i >= NODES || pend[i] == 0) return;
      node_max[i] += pend[i];
      if (l != r && 2*i+1 < NODES) begin
         pend[2*i]   += pend[i];
         pend[2*i+1] += pend[i];
      end
      pend[i] = 0;
   endfunction

   function void add_over(int i, int l, int r, int a, int b, bit signed [31:0] v);
      int mid;
      if (i >= NODES) return;
      push(i, l, r);
      if (l > b || a > r || l > r) return;
      if (a <= l && b >= r) begin
         node_max[i] += v;
         if (l != r && 2*i+1 < NODES) begin
            pend[2*i]   += v;
            pend[2*i+1] += v;
         end
         return;
      end
      if (2*i+1 >= NODES) return;
      mid = (l + r) / 2;
      add_over(2*i, l, mid, a, b, v);
      add_over(2*i+1, mid+1, r, a, b, v);
      node_max[i] = (node_max[2*i+1] > node_max[2*i]) ? node_max[2*i+1] : node_max[2*i];
   endfunction

   function bit max_over(int i, int l, int r, int a, int b, output bit signed [31:0] res);
      int mid;
      bit signed [31:0] lv, rv;
      bit lok, rok;
      res = 0;
      if (i >= NODES) return 0;
      push(i, l, r);
      if (l > b || a > r || l > r) return 0;
      if (a <= l && b >= r) begin
         res = node_max[i];
         return 1;
      end
      if (2*i+1 >= NODES) return 0;
      mid = (l + r) / 2;
      lok = max_over(2*i, l, mid, a, b, lv);
      rok = max_over(2*i+1, mid+1, r, a, b, rv);
      if (lok && rok) res = (rv > lv) ? rv : lv;
      else if (lok) res = lv;
      else if (rok) res = rv;
      return lok || rok;
   endfunction

   function void note_request(logic op, int lo, int hi, bit signed [31:0] v);
      bit signed [31:0] m;
      if (op == ramt_pkg::OP_ADD) begin
         if (n_pos >= 1) add_over(1, 1, n_pos, lo, hi, v);
      end else begin
         if (!(n_pos >= 1 && max_over(1, 1, n_pos, lo, hi, m))) m = ramt_pkg::EMPTY_MARK;
         pending_max.push_back(m);
      end
   endfunction

   function void check_result(logic [31:0] got);
      bit signed [31:0] want;
      if (pending_max.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result %0d", $signed(got));
         return;
      end
      want = pending_max.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("range_max mismatch: expected %0d, got %0d", want, $signed(got));
      end
   endfunction
endclass

module testbench;
   import ramt_pkg::*;

   localparam int SETTLE = 400;
   localparam int LIMIT  = 4000000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic        csr_wen = 0;
   logic [10:0] csr_wdata = '0;

   max_tree_scoreboard sb = new();
   bit quiet = 0;
   int cycles = 0;

   range_add_range_max_tree_top i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("simulation failed");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // receiver: stalls in bursts, none once quiet
   initial begin
      int k;
      @(negedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 0;
            k = $urandom_range(1, 11);
            repeat (k) @(negedge clock);
         end
         rsp_tready <= 1;
         k = $urandom_range(1, 20);
         repeat (k) @(negedge clock);
      end
   end

   // one transaction; valid stays high on return, caller lowers it
   task automatic send(logic op, logic [10:0] lo, logic [10:0] hi, logic [31:0] v);
      int k;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 0;
         k = $urandom_range(1, 11);
         repeat (k) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, v, hi, lo};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, lo, hi, v);
      @(negedge clock);
   endtask

   // waits until the block is idle and every expected result has come
   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending_max.size() != 0) @(negedge clock);
      while (!req_tready) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic set_positions(logic [10:0] value);
      drain();
      csr_wen   <= 1;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 0;
      sb.clear_tree(value);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 40) - 20;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_items(int count);
      logic [10:0] lo, hi;
      int top;
      top = (sb.n_pos + 2 > 2047) ? 2047 : sb.n_pos + 2;
      repeat (count) begin
         if ($urandom_range(0, 7) == 0) begin
            lo = 11'($urandom_range(0, 2047));
            hi = 11'($urandom_range(0, 2047));
         end else begin
            lo = 11'($urandom_range(0, top));
            hi = 11'($urandom_range(lo, top));
         end
         send(1'($urandom_range(0, 1)), lo, hi, pick_value());
      end
   endtask

   initial begin
      sb.clear_tree(POS_RESET);
      repeat (9) @(negedge clock);
      reset <= 0;

      // directed: extremes, wrap, empty and reversed ranges
      send(OP_QUERY, 1, 1024, 0);
      send(OP_QUERY, 0, 0, 0);
      send(OP_ADD, 1, 1024, 32'h7fff_ffff);
      send(OP_QUERY, 1, 1024, 0);
      send(OP_ADD, 512, 512, 1);
      send(OP_QUERY, 500, 600, 0);
      send(OP_QUERY, 1, 511, 0);
      send(OP_ADD, 1, 2047, 32'h8000_0000);
      send(OP_QUERY, 1, 2047, 0);
      send(OP_QUERY, 1025, 2047, 0);
      send(OP_QUERY, 700, 300, 0);
      send(OP_ADD, 700, 300, 5);
      send(OP_ADD, 1024, 1024, 32'hfa0a_1f01);
      send(OP_QUERY, 1024, 1024, 0);
      send(OP_QUERY, 2047, 0, 32'hffff_ffff);
      send(OP_ADD, 0, 1, 32'hffff_ffff);
      send(OP_QUERY, 1, 1, 0);
      set_positions(0);
      send(OP_ADD, 1, 1024, 9);
      send(OP_QUERY, 1, 1024, 0);
      set_positions(2047);
      send(OP_QUERY, 1024, 1024, 0);
      set_positions(1);
      send(OP_ADD, 1, 1, -3);
      send(OP_QUERY, 1, 2, 0);
      send(OP_QUERY, 2, 2, 0);

      random_items(200);
      set_positions(7);
      random_items(250);
      set_positions(1024);
      random_items(150);
      drain();                  // sender waits for every result
      random_items(150);
      set_positions(2047);
      random_items(150);
      set_positions(100);
      random_items(250);
      set_positions(0);
      random_items(50);
      set_positions(16);
      random_items(200);
      quiet = 1;
      random_items(200);
      req_tvalid <= 0;

      while (sb.pending_max.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending_max.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

[filelist.f]
+incdir+design
design/ramt_pkg.sv
design/ramt_dp.sv
design/ramt_ctrl.sv
design/range_add_range_max_tree_top.sv
tb/testbench.sv
